FILE: sv/ifmt_pkg.sv
// Shared types, constants and helpers for the integer field formatter.
// No dependencies; every other file imports this package.
`default_nettype none

package ifmt_pkg;

   localparam int MAX_FIELD_DEFAULT = 63;
   localparam int QUEUE_DEPTH       = 2;
   localparam int DIGITS_MAX        = 10;
   localparam int DIGIT_CNT_W       = $clog2(DIGITS_MAX + 1);
   localparam int DIGIT_IDX_W       = $clog2(DIGITS_MAX);
   localparam int FIELD_W           = 6;

   localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   localparam logic CMD_DEC = 1'b0;
   localparam logic CMD_HEX = 1'b1;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_CONV,
      FE_SEND
   } front_state_type;

   typedef struct packed {
      logic [DIGITS_MAX-1:0][3:0] digits;
      logic [DIGIT_CNT_W-1:0]     ndig;
      logic                       neg;
      logic [FIELD_W-1:0]         zeros;
      logic [FIELD_W-1:0]         spaces;
   } field_desc_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + {4'b0, d};
      end else begin
         c = CHAR_LOW_A + {4'b0, d} - 8'd10;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: sv/ifmt_front.sv
// Front end: accepts a request, splits the magnitude into digits one per cycle
// and sizes the padding. Depends on ifmt_pkg.
`default_nettype none

module ifmt_front import ifmt_pkg::*; #(
   parameter int MAX_FIELD = MAX_FIELD_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic               req_cmd,
   input  wire logic [31:0]        req_value,
   input  wire logic [FIELD_W-1:0] req_field_width,
   input  wire logic               req_precision_given,
   input  wire logic [FIELD_W-1:0] req_min_digits,
   output logic                    q_push,
   input  wire logic               q_full,
   output field_desc_type          q_desc
);

   front_state_type            state_ff, state_in;
   logic                       hex_ff, hex_in;
   logic                       neg_ff, neg_in;
   logic [31:0]                mag_ff, mag_in;
   logic [FIELD_W-1:0]         width_ff, width_in;
   logic [FIELD_W-1:0]         prec_ff, prec_in;
   logic [DIGIT_CNT_W-1:0]     ndig_ff, ndig_in;
   logic [DIGITS_MAX-1:0][3:0] digs_ff, digs_in;

   logic [63:0]        prod;
   logic [31:0]        quot;
   logic [3:0]         digit;
   logic [31:0]        mag_next;
   logic [FIELD_W-1:0] width_clamp;
   logic [FIELD_W-1:0] prec_clamp;
   logic               neg_req;
   logic [FIELD_W-1:0] zeros;
   logic [FIELD_W:0]   body;

   assign prod  = {32'b0, mag_ff} * {32'b0, RECIP_TEN};
   assign quot  = 32'(prod >> RECIP_SHIFT);
   assign digit = hex_ff ? mag_ff[3:0] : 4'(mag_ff - ((quot << 3) + (quot << 1)));
   assign mag_next = hex_ff ? (mag_ff >> 4) : quot;

   assign width_clamp = (32'(req_field_width) > MAX_FIELD) ? FIELD_W'(MAX_FIELD)
                                                           : req_field_width;
   assign prec_clamp  = !req_precision_given ? '0 :
                        (32'(req_min_digits) > MAX_FIELD) ? FIELD_W'(MAX_FIELD)
                                                          : req_min_digits;
   assign neg_req = (req_cmd == CMD_DEC) && req_value[31];

   assign zeros = (prec_ff > FIELD_W'(ndig_ff)) ? prec_ff - FIELD_W'(ndig_ff) : '0;
   assign body  = (FIELD_W+1)'(neg_ff) + (FIELD_W+1)'(zeros) + (FIELD_W+1)'(ndig_ff);

   always_comb begin
      q_desc.digits = digs_ff;
      q_desc.ndig   = ndig_ff;
      q_desc.neg    = neg_ff;
      q_desc.zeros  = zeros;
      q_desc.spaces = ((FIELD_W+1)'(width_ff) > body) ?
                      FIELD_W'((FIELD_W+1)'(width_ff) - body) : '0;
   end

   always_comb begin
      state_in = state_ff;
      hex_in   = hex_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      width_in = width_ff;
      prec_in  = prec_ff;
      ndig_in  = ndig_ff;
      digs_in  = digs_ff;
      full     = 1'b1;
      q_push   = 1'b0;
      unique case (state_ff)
         FE_IDLE: begin
            full = 1'b0;
            if (push) begin
               hex_in   = (req_cmd == CMD_HEX);
               neg_in   = neg_req;
               mag_in   = neg_req ? (32'd0 - req_value) : req_value;
               width_in = width_clamp;
               prec_in  = prec_clamp;
               ndig_in  = '0;
               if (req_precision_given && prec_clamp == '0 && req_value == 32'd0) begin
                  state_in = FE_SEND;
               end else begin
                  state_in = FE_CONV;
               end
            end
         end
         FE_CONV: begin
            digs_in[ndig_ff[DIGIT_IDX_W-1:0]] = digit;
            ndig_in = ndig_ff + 1'b1;
            mag_in  = mag_next;
            if (mag_next == 32'd0) begin
               state_in = FE_SEND;
            end
         end
         FE_SEND: begin
            q_push = 1'b1;
            if (!q_full) begin
               state_in = FE_IDLE;
            end
         end
         default: state_in = FE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      hex_ff   <= hex_in;
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      width_ff <= width_in;
      prec_ff  <= prec_in;
      ndig_ff  <= ndig_in;
      digs_ff  <= digs_in;
   end

endmodule

`default_nettype wire

FILE: sv/ifmt_queue.sv
// Short descriptor queue between front and back end.
// Depends on ifmt_pkg for the descriptor type.
`default_nettype none

module ifmt_queue import ifmt_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire field_desc_type wr_desc,
   output logic                full,
   input  wire logic           pop,
   output field_desc_type      rd_desc,
   output logic                empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   field_desc_type     slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push;
   logic               do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_desc = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_desc;
      end
   end

endmodule

`default_nettype wire

FILE: sv/ifmt_back.sv
// Back end: walks one field descriptor and emits one character per cycle into the
// output register whenever that register is empty or being popped. Depends on ifmt_pkg.
`default_nettype none

module ifmt_back import ifmt_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           q_empty,
   input  wire field_desc_type q_desc,
   output logic                q_pop,
   output logic                busy,
   output logic                empty,
   input  wire logic           pop,
   output logic [7:0]          rsp_char_out,
   output logic                rsp_last_char
);

   logic [FIELD_W-1:0]         sp_ff, sp_in;
   logic                       ng_ff, ng_in;
   logic [FIELD_W-1:0]         zr_ff, zr_in;
   logic [DIGIT_CNT_W-1:0]     dg_ff, dg_in;
   logic [DIGITS_MAX-1:0][3:0] digs_ff, digs_in;
   logic                       valid_ff, valid_in;
   logic [7:0]                 char_ff, char_in;
   logic                       last_ff, last_in;

   logic                       slot_free;
   logic [DIGIT_CNT_W-1:0]     dg_idx;

   assign busy      = (sp_ff != '0) || ng_ff || (zr_ff != '0) || (dg_ff != '0);
   assign slot_free = !valid_ff || pop;
   assign q_pop     = !busy && !q_empty;
   assign dg_idx    = dg_ff - 1'b1;

   assign empty         = !valid_ff;
   assign rsp_char_out  = char_ff;
   assign rsp_last_char = last_ff;

   always_comb begin
      sp_in    = sp_ff;
      ng_in    = ng_ff;
      zr_in    = zr_ff;
      dg_in    = dg_ff;
      digs_in  = digs_ff;
      valid_in = valid_ff && !pop;
      char_in  = char_ff;
      last_in  = last_ff;
      if (q_pop) begin
         sp_in   = q_desc.spaces;
         ng_in   = q_desc.neg;
         zr_in   = q_desc.zeros;
         dg_in   = q_desc.ndig;
         digs_in = q_desc.digits;
      end else if (busy && slot_free) begin
         priority if (sp_ff != '0) begin
            char_in = CHAR_SPACE;
            sp_in   = sp_ff - 1'b1;
         end else if (ng_ff) begin
            char_in = CHAR_MINUS;
            ng_in   = 1'b0;
         end else if (zr_ff != '0) begin
            char_in = CHAR_ZERO;
            zr_in   = zr_ff - 1'b1;
         end else begin
            char_in = digit_char(digs_ff[dg_idx[DIGIT_IDX_W-1:0]]);
            dg_in   = dg_idx;
         end
         valid_in = 1'b1;
         last_in  = (sp_in == '0) && !ng_in && (zr_in == '0) && (dg_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff    <= '0;
         ng_ff    <= 1'b0;
         zr_ff    <= '0;
         dg_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         sp_ff    <= sp_in;
         ng_ff    <= ng_in;
         zr_ff    <= zr_in;
         dg_ff    <= dg_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digs_ff <= digs_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

FILE: sv/integer_field_formatter.sv
// Top level of the integer field formatter: front end, descriptor queue, back end.
// Depends on ifmt_pkg, ifmt_front, ifmt_queue and ifmt_back.
//
// Formats a 32-bit value as a printf-style decimal or lower-case hex field and
// streams it out one ASCII character per beat, last_char marking the final one;
// a zero value with an explicit zero precision and zero width produces no beats.
// The front end takes a request, then splits the magnitude into digits (up to 10 for
// decimal, 8 for hex) and hands the descriptor to the queue, holding it while the queue
// is full; it takes no new request until that hand-off is done. The back end loads each
// field, then emits one character per cycle while the output is empty or being popped;
// a two-entry queue lets the two run apart.
`default_nettype none

module integer_field_formatter import ifmt_pkg::*; #(
   parameter int MAX_FIELD   = MAX_FIELD_DEFAULT,
   parameter int QUEUE_SLOTS = QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic               req_cmd,
   input  wire logic [31:0]        req_value,
   input  wire logic [FIELD_W-1:0] req_field_width,
   input  wire logic               req_precision_given,
   input  wire logic [FIELD_W-1:0] req_min_digits,
   output logic                    empty,
   input  wire logic               pop,
   output logic [7:0]              rsp_char_out,
   output logic                    rsp_last_char
);

   logic           q_push;
   logic           q_full;
   logic           q_pop;
   logic           q_empty;
   logic           back_busy;
   field_desc_type wr_desc;
   field_desc_type rd_desc;

   ifmt_front #(
      .MAX_FIELD (MAX_FIELD)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_cmd             (req_cmd),
      .req_value           (req_value),
      .req_field_width     (req_field_width),
      .req_precision_given (req_precision_given),
      .req_min_digits      (req_min_digits),
      .q_push              (q_push),
      .q_full              (q_full),
      .q_desc              (wr_desc)
   );

   ifmt_queue #(
      .DEPTH (QUEUE_SLOTS)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_desc (wr_desc),
      .full    (q_full),
      .pop     (q_pop),
      .rd_desc (rd_desc),
      .empty   (q_empty)
   );

   ifmt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_desc        (rd_desc),
      .q_pop         (q_pop),
      .busy          (back_busy),
      .empty         (empty),
      .pop           (pop),
      .rsp_char_out  (rsp_char_out),
      .rsp_last_char (rsp_last_char)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      push && !full |=> full)
      else $error("front end took a request but did not go busy");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty && !back_busy)
      else $error("back end loaded a descriptor from an empty queue or while busy");

   a_hold_handoff: assert property (@(posedge clock) disable iff (reset)
      q_push && q_full |=> q_push)
      else $error("front end dropped a descriptor while the queue was full");

   a_load_then_idle_out: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !(back_busy && $past(back_busy)))
      else $error("back end loaded a descriptor while still emitting a field");

endmodule

`default_nettype wire

FILE: tb/integer_field_formatter_tb.sv
// Testbench for integer_field_formatter: directed and random conversion requests,
// each predicted character by character and checked against every result beat.
// Depends on ifmt_pkg and the integer_field_formatter RTL only.
`timescale 1ns / 1ps

module integer_field_formatter_tb;
   import ifmt_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLD_OFF      = 24;
   localparam int SETTLE_CYCLES = 80;
   localparam int REPORT_MAX    = 10;

   typedef struct packed {
      logic [7:0] ch;
      logic       is_last;
   } field_char_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               pop = 1'b0;
   logic               req_cmd = CMD_DEC;
   logic [31:0]        req_value = '0;
   logic [FIELD_W-1:0] req_field_width = '0;
   logic               req_precision_given = 1'b0;
   logic [FIELD_W-1:0] req_min_digits = '0;
   logic               full;
   logic               empty;
   logic [7:0]         rsp_char_out;
   logic               rsp_last_char;

   field_char_type pending_chars[$];
   field_char_type head_char;
   int             mismatch_count = 0;
   int             idle_cycles = 0;
   int             pop_stall = 0;
   bit             no_idle = 1'b0;

   integer_field_formatter dut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_cmd             (req_cmd),
      .req_value           (req_value),
      .req_field_width     (req_field_width),
      .req_precision_given (req_precision_given),
      .req_min_digits      (req_min_digits),
      .empty               (empty),
      .pop                 (pop),
      .rsp_char_out        (rsp_char_out),
      .rsp_last_char       (rsp_last_char)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Append the characters of one formatted field to the expected stream.
   function automatic void predict_field(input logic cmd, input logic [31:0] value,
                                         input logic [FIELD_W-1:0] width,
                                         input logic prec_on,
                                         input logic [FIELD_W-1:0] prec_in);
      logic [31:0]    mag;
      logic [31:0]    radix;
      logic [3:0]     digs[16];
      logic           neg;
      int             ndig;
      int             prec;
      int             zeros;
      int             body;
      int             spaces;
      int             first;
      field_char_type fc;
      neg   = (cmd == CMD_DEC) && value[31];
      mag   = neg ? (32'd0 - value) : value;
      radix = (cmd == CMD_HEX) ? 32'd16 : 32'd10;
      prec  = prec_on ? int'(prec_in) : 0;
      ndig  = 0;
      if (!(prec_on && prec == 0 && value == 32'd0)) begin
         do begin
            digs[ndig] = 4'(mag % radix);
            mag = mag / radix;
            ndig++;
         end while (mag != 32'd0);
      end
      zeros  = (prec > ndig) ? prec - ndig : 0;
      body   = int'(neg) + zeros + ndig;
      spaces = (int'(width) > body) ? int'(width) - body : 0;
      first  = pending_chars.size();
      fc.is_last = 1'b0;
      for (int i = 0; i < spaces; i++) begin
         fc.ch = CHAR_SPACE;
         pending_chars.push_back(fc);
      end
      if (neg) begin
         fc.ch = CHAR_MINUS;
         pending_chars.push_back(fc);
      end
      for (int i = 0; i < zeros; i++) begin
         fc.ch = CHAR_ZERO;
         pending_chars.push_back(fc);
      end
      for (int i = ndig - 1; i >= 0; i--) begin
         fc.ch = (digs[i] < 4'd10) ? CHAR_ZERO + 8'(digs[i])
                                   : CHAR_LOW_A + 8'(digs[i]) - 8'd10;
         pending_chars.push_back(fc);
      end
      if (pending_chars.size() > first)
         pending_chars[pending_chars.size() - 1].is_last = 1'b1;
   endfunction

   task automatic send_field(input logic cmd, input logic [31:0] value,
                             input logic [FIELD_W-1:0] width, input logic prec_on,
                             input logic [FIELD_W-1:0] digits);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push                <= 1'b1;
      req_cmd             <= cmd;
      req_value           <= value;
      req_field_width     <= width;
      req_precision_given <= prec_on;
      req_min_digits      <= digits;
      do @(posedge clock); while (full);
      predict_field(cmd, value, width, prec_on, digits);
   endtask

   task automatic send_random_field();
      logic [31:0]        value;
      logic [FIELD_W-1:0] width;
      logic [FIELD_W-1:0] digits;
      logic               cmd;
      logic               prec_on;
      cmd = $urandom_range(1) ? CMD_HEX : CMD_DEC;
      case ($urandom_range(9))
         0: value = 32'd0;
         1: value = $urandom_range(99);
         2: begin
            case ($urandom_range(2))
               0: value = 32'h8000_0000;
               1: value = 32'h7fff_ffff;
               default: value = 32'hffff_ffff;
            endcase
         end
         3: value = 32'd0 - 32'($urandom_range(1000, 1));
         default: value = $urandom;
      endcase
      width   = ($urandom_range(99) < 85) ? FIELD_W'($urandom_range(16))
                                          : FIELD_W'($urandom_range(63));
      prec_on = 1'($urandom_range(1));
      digits  = ($urandom_range(99) < 80) ? FIELD_W'($urandom_range(12))
                                          : FIELD_W'($urandom_range(63));
      send_field(cmd, value, width, prec_on, digits);
   endtask

   // Hold the sender until every predicted character has come back.
   task automatic drain_all();
      push <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input field_char_type want);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("%0t %s: expected char %h last %b, got char %h last %b", $realtime,
                  what, want.ch, want.is_last, rsp_char_out, rsp_last_char);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (pop_stall > 0) begin
         pop       <= 1'b0;
         pop_stall <= pop_stall - 1;
      end else begin
         pop <= 1'b1;
         if (pop && !empty) pop_stall <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (pending_chars.size() == 0) begin
            report_mismatch("unexpected beat", '0);
         end else begin
            head_char = pending_chars.pop_front();
            if (rsp_char_out !== head_char.ch || rsp_last_char !== head_char.is_last)
               report_mismatch("wrong beat", head_char);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("timeout after %0d cycles without a beat", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   task automatic test_directed_fields();
      send_field(CMD_DEC, 32'd0, 6'd0, 1'b0, 6'd0);
      send_field(CMD_DEC, 32'd0, 6'd0, 1'b1, 6'd0);
      send_field(CMD_DEC, 32'd0, 6'd7, 1'b1, 6'd0);
      send_field(CMD_HEX, 32'd0, 6'd0, 1'b1, 6'd0);
      send_field(CMD_HEX, 32'd0, 6'd0, 1'b0, 6'd63);
      send_field(CMD_HEX, 32'd0, 6'd0, 1'b1, 6'd1);
      send_field(CMD_DEC, 32'h7fff_ffff, 6'd0, 1'b0, 6'd0);
      send_field(CMD_DEC, 32'h8000_0000, 6'd0, 1'b0, 6'd0);
      send_field(CMD_DEC, 32'h8000_0000, 6'd63, 1'b1, 6'd63);
      send_field(CMD_DEC, 32'hffff_ffff, 6'd5, 1'b1, 6'd3);
      send_field(CMD_DEC, 32'hffff_fffb, 6'd0, 1'b1, 6'd0);
      send_field(CMD_HEX, 32'hffff_ffff, 6'd0, 1'b0, 6'd0);
      send_field(CMD_HEX, 32'h89ab_cdef, 6'd12, 1'b1, 6'd10);
      send_field(CMD_HEX, 32'h0123_4567, 6'd0, 1'b1, 6'd63);
      send_field(CMD_HEX, 32'h8000_0000, 6'd0, 1'b1, 6'd0);
      send_field(CMD_HEX, 32'h0000_000a, 6'd1, 1'b0, 6'd0);
      send_field(CMD_DEC, 32'd1234567890, 6'd3, 1'b0, 6'd0);
      send_field(CMD_DEC, 32'd42, 6'd63, 1'b0, 6'd40);
      send_field(CMD_DEC, 32'd0, 6'd63, 1'b1, 6'd63);
      send_field(CMD_DEC, 32'd1, 6'd1, 1'b1, 6'd1);
      send_field(CMD_DEC, 32'd999_999_999, 6'd21, 1'b1, 6'd20);
      send_field(CMD_HEX, 32'h0000_0fff, 6'd2, 1'b1, 6'd2);
   endtask

   task automatic test_random_fields(input int count);
      for (int i = 0; i < count; i++) send_random_field();
   endtask

   task automatic test_back_to_back(input int count);
      no_idle = 1'b1;
      for (int i = 0; i < count; i++) send_random_field();
      no_idle = 1'b0;
   endtask

   task automatic test_drain_pause();
      for (int i = 0; i < 12; i++) send_random_field();
      drain_all();
      send_field(CMD_DEC, 32'd0, 6'd0, 1'b1, 6'd0);
      send_field(CMD_HEX, 32'd0, 6'd0, 1'b1, 6'd0);
      drain_all();
      send_field(CMD_HEX, 32'hdead_beef, 6'd9, 1'b0, 6'd0);
      drain_all();
      for (int i = 0; i < 21; i++) send_random_field();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_fields();
      test_random_fields(120);
      test_back_to_back(30);
      test_drain_pause();
      push <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_chars.size() != 0) begin
         mismatch_count += pending_chars.size();
         $display("%0d expected beats never arrived", pending_chars.size());
      end
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
